// ----- rtl/fqrv_pkg.sv -----
// Types and codes shared by the queue controller, datapath and top level.
package fqrv_pkg;

    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int HEAD_W  = 32;
    localparam int COUNT_W = 5;
    localparam int VALUE_W = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_NOMATCH = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SRCH = 2'd1,
        ST_UPDT = 2'd2,
        ST_RESP = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic search;
        logic update;
        logic respond;
    } t_cmd;

endpackage

// ----- rtl/fqrv_ctrl.sv -----
// Sequencing state machine and output word valid for the queue.
module fqrv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output fqrv_pkg::t_cmd o_cmd
);

    fqrv_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fqrv_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = fqrv_pkg::ST_SRCH;
                end
            end
            fqrv_pkg::ST_SRCH: begin
                n_state = fqrv_pkg::ST_UPDT;
            end
            fqrv_pkg::ST_UPDT: begin
                n_state = fqrv_pkg::ST_RESP;
            end
            fqrv_pkg::ST_RESP: begin
                if (out_free) begin
                    n_state = fqrv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fqrv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            fqrv_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            fqrv_pkg::ST_SRCH: begin
                o_cmd.search = 1'b1;
            end
            fqrv_pkg::ST_UPDT: begin
                o_cmd.update = 1'b1;
            end
            fqrv_pkg::ST_RESP: begin
                if (out_free) begin
                    o_cmd.respond = 1'b1;
                    n_out_valid   = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fqrv_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.search, o_cmd.update, o_cmd.respond}))
        else $error("more than one datapath command at once");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.respond |-> (!r_out_valid || i_m_tready))
        else $error("response loaded over a word not yet taken");

    a_load_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.search ##1 o_cmd.update)
        else $error("accepted word not searched and updated in order");
`endif

endmodule

// ----- rtl/fqrv_datapath.sv -----
// Queue cells, per-cell match, gap-closing shift and result register.
module fqrv_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fqrv_pkg::t_cmd                   i_cmd,
    input  logic [fqrv_pkg::ACT_W-1:0]       i_action,
    input  logic signed [fqrv_pkg::VALUE_W-1:0] i_value,
    output logic signed [fqrv_pkg::HEAD_W-1:0]  o_head_value,
    output logic                             o_empty_res,
    output logic [fqrv_pkg::COUNT_W-1:0]     o_count,
    output logic [fqrv_pkg::STAT_W-1:0]      o_status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0]        r_cell [DEPTH];
    logic [DATA_WIDTH-1:0]        n_cell [DEPTH];
    logic [CW-1:0]                r_count, n_count;
    logic [DEPTH-1:0]             r_match, n_match;
    fqrv_pkg::t_action            r_action;
    logic [DATA_WIDTH-1:0]        r_value;
    fqrv_pkg::t_status            r_status, n_status;

    logic signed [fqrv_pkg::HEAD_W-1:0] r_head;
    logic                         r_empty;
    logic [fqrv_pkg::COUNT_W-1:0] r_count_out;
    fqrv_pkg::t_status            r_status_out;

    logic [DATA_WIDTH-1:0]        value_ext;
    logic [fqrv_pkg::HEAD_W-1:0]  head_ext;
    logic [fqrv_pkg::COUNT_W-1:0] count_ext;
    logic [DEPTH-1:0]             valid;
    logic [DEPTH-1:0]             eq;
    logic [DEPTH-1:0]             ge;
    logic                         found;
    logic                         full;

    generate
        if (DATA_WIDTH <= fqrv_pkg::VALUE_W) begin : g_val_narrow
            assign value_ext = i_value[DATA_WIDTH-1:0];
        end else begin : g_val_wide
            assign value_ext = {{(DATA_WIDTH-fqrv_pkg::VALUE_W){i_value[fqrv_pkg::VALUE_W-1]}},
                                i_value};
        end
        if (DATA_WIDTH >= fqrv_pkg::HEAD_W) begin : g_head_wide
            assign head_ext = r_cell[0][fqrv_pkg::HEAD_W-1:0];
        end else begin : g_head_narrow
            assign head_ext = {{(fqrv_pkg::HEAD_W-DATA_WIDTH){r_cell[0][DATA_WIDTH-1]}},
                               r_cell[0]};
        end
        if (CW >= fqrv_pkg::COUNT_W) begin : g_cnt_wide
            assign count_ext = r_count[fqrv_pkg::COUNT_W-1:0];
        end else begin : g_cnt_narrow
            assign count_ext = {{(fqrv_pkg::COUNT_W-CW){1'b0}}, r_count};
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid[i] = CW'(i) < r_count;
            eq[i]    = r_cell[i] == r_value;
        end
    end

    assign full  = r_count == CW'(DEPTH);
    assign found = |r_match;
    // all cells at or above the first match
    assign ge    = r_match | (~r_match + DEPTH'(1));

    always_comb begin
        n_match = '0;
        case (r_action)
            fqrv_pkg::ACT_POP: begin
                n_match[0] = r_count != '0;
            end
            fqrv_pkg::ACT_REMOVE: begin
                n_match = eq & valid;
            end
            default: begin
                n_match = '0;
            end
        endcase
    end

    always_comb begin
        n_cell   = r_cell;
        n_count  = r_count;
        n_status = fqrv_pkg::STAT_OK;
        case (r_action)
            fqrv_pkg::ACT_PUSH: begin
                if (full) begin
                    n_status = fqrv_pkg::STAT_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CW'(i) == r_count) begin
                            n_cell[i] = r_value;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            fqrv_pkg::ACT_POP, fqrv_pkg::ACT_REMOVE: begin
                if (found) begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (ge[i]) begin
                            n_cell[i] = r_cell[i+1];
                        end
                    end
                    n_count = r_count - CW'(1);
                end else if (r_action == fqrv_pkg::ACT_POP) begin
                    n_status = fqrv_pkg::STAT_EMPTY;
                end else begin
                    n_status = fqrv_pkg::STAT_NOMATCH;
                end
            end
            default: begin
                n_status = fqrv_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_match <= '0;
        end else begin
            if (i_cmd.search) begin
                r_match <= n_match;
            end
            if (i_cmd.update) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= fqrv_pkg::t_action'(i_action);
            r_value  <= value_ext;
        end
        if (i_cmd.update) begin
            r_cell   <= n_cell;
            r_status <= n_status;
        end
        if (i_cmd.respond) begin
            r_head       <= (r_count == '0) ? '0 : head_ext;
            r_empty      <= r_count == '0;
            r_count_out  <= count_ext;
            r_status_out <= r_status;
        end
    end

    assign o_head_value = r_head;
    assign o_empty_res  = r_empty;
    assign o_count      = r_count_out;
    assign o_status     = r_status_out;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    a_match_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> ((r_match & ~valid) == '0))
        else $error("match flagged on an unheld cell");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_action == fqrv_pkg::ACT_PUSH && !full)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not grow the queue");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && found) |=> r_count == $past(r_count) - CW'(1))
        else $error("matched removal did not shrink the queue");
`endif

endmodule

// ----- rtl/fifo_queue_with_remove_by_value.sv -----
// Top level of the ordered queue with removal by value.
//
//  channel  | direction | tdata fields (lowest bit up)
//  s_axis   | in        | action[1:0], value[33:2], zero pad [39:34]
//  m_axis   | out       | head_value[31:0], empty_res[32], count[37:33], status[39:38]
//
// Each word passes through four steps: accept, search, update, respond.
// The search compares every cell at once; the update shifts the cells past
// the first match down by one place.
// Reset clears the occupancy and the handshake state; cell contents stay.
// The result waits in an output register; the next word is accepted while it
// waits, and the respond step holds until that register is free.
module fifo_queue_with_remove_by_value #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // action, value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // head_value, empty_res, count, status
);

    fqrv_pkg::t_cmd                        cmd;
    logic signed [fqrv_pkg::HEAD_W-1:0]    head_value;
    logic                                  empty_res;
    logic [fqrv_pkg::COUNT_W-1:0]          count;
    logic [fqrv_pkg::STAT_W-1:0]           status;

    fqrv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_cmd      (cmd)
    );

    fqrv_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_s_axis_tdata[1:0]),
        .i_value      (i_s_axis_tdata[33:2]),
        .o_head_value (head_value),
        .o_empty_res  (empty_res),
        .o_count      (count),
        .o_status     (status)
    );

    assign o_m_axis_tdata = {status, count, empty_res, head_value};

endmodule
